>>> rtl/sfe_pkg.sv
package sfe_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 7;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned ACT_W   = 2;

    // configuration register indexes
    localparam logic REG_HEADER = 1'b0;
    localparam logic REG_TAIL   = 1'b1;

    localparam logic [7:0]  HEADER_RESET = 8'hAA;
    localparam logic [31:0] TAIL_RESET   = 32'hFFFC_FFFF;

    // command bytes that select the action
    localparam logic [7:0] CMD_LEAD    = 8'hAA;
    localparam logic [7:0] CMD_DEMAG   = 8'h08;
    localparam logic [7:0] CMD_DAMPING = 8'h09;

    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEMAG   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DAMPING = 2'd2;

    typedef struct packed {
        logic accept;   // input transaction taken this cycle
        logic load;     // capture read data into the output register
        logic pop;      // output transaction taken this cycle
    } t_cmd;

    typedef struct packed {
        logic match;    // accepted byte closes a frame
        logic last;     // current read position is the final byte
    } t_status;

endpackage

>>> rtl/sfe_ram.sv
module sfe_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/sfe_ctrl.sv
module sfe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_stall,
    input  sfe_pkg::t_status i_status,
    output sfe_pkg::t_cmd    o_cmd,
    output logic             o_in_stall,
    output logic             o_out_valid
);
    import sfe_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.load   = (r_state == S_LOAD);
        o_cmd.pop    = (r_state == S_HOLD) && !i_out_stall;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept && i_status.match) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_LOAD;
            S_LOAD: n_state = S_HOLD;
            S_HOLD: begin
                if (o_cmd.pop) begin
                    n_state = i_status.last ? S_IDLE : S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_HOLD);

endmodule

>>> rtl/sfe_dp.sv
module sfe_dp #(
    parameter int unsigned FRAME_DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sfe_pkg::t_cmd               i_cmd,
    output sfe_pkg::t_status            o_status,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    input  logic [sfe_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic [sfe_pkg::BYTE_W-1:0]  o_frame_byte,
    output logic [sfe_pkg::INDEX_W-1:0] o_byte_index,
    output logic                        o_last_byte,
    output logic [sfe_pkg::POS_W-1:0]   o_frame_length,
    output logic [sfe_pkg::ACT_W-1:0]   o_action
);
    import sfe_pkg::*;

    localparam int unsigned AW = $clog2(FRAME_DEPTH);
    localparam logic [POS_W-1:0] DEPTH_LIM = POS_W'(FRAME_DEPTH);

    logic [BYTE_W-1:0]  r_header;
    logic [31:0]        r_tail;
    logic [POS_W-1:0]   r_wpos;
    logic [31:0]        r_window;
    logic [BYTE_W-1:0]  r_byte0;
    logic [BYTE_W-1:0]  r_byte1;
    logic [POS_W-1:0]   r_len;
    logic [ACT_W-1:0]   r_act;
    logic [AW-1:0]      r_rd;
    logic [BYTE_W-1:0]  r_frame_byte;
    logic [INDEX_W-1:0] r_byte_index;
    logic               r_last_byte;

    logic [31:0]        n_window;
    logic [POS_W-1:0]   n_wpos;
    logic [POS_W-1:0]   n_len;
    logic [ACT_W-1:0]   n_act;
    logic [BYTE_W-1:0]  n_byte0;
    logic [BYTE_W-1:0]  n_byte1;
    logic               drop;
    logic               store;
    logic               rd_last;
    logic [BYTE_W-1:0]  rdata;

    always_comb begin
        drop     = (r_wpos == '0) && (i_rx_byte != r_header);
        store    = i_cmd.accept && !drop && (r_wpos < DEPTH_LIM);
        n_window = {r_window[23:0], i_rx_byte};
        n_wpos   = store ? r_wpos + POS_W'(1) : r_wpos;
        n_byte0  = (store && r_wpos == POS_W'(0)) ? i_rx_byte : r_byte0;
        n_byte1  = (store && r_wpos == POS_W'(1)) ? i_rx_byte : r_byte1;
        n_len    = n_wpos;
        n_act    = ACT_NONE;
        if (n_len > POS_W'(2) && n_byte0 == CMD_LEAD) begin
            if (n_byte1 == CMD_DEMAG) begin
                n_act = ACT_DEMAG;
            end else if (n_byte1 == CMD_DAMPING) begin
                n_act = ACT_DAMPING;
            end
        end
        rd_last = (POS_W'(r_rd) + POS_W'(1)) == r_len;
    end

    assign o_status.match = !drop && (n_window == r_tail);
    assign o_status.last  = r_last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
            r_tail   <= TAIL_RESET;
            r_wpos   <= '0;
            r_window <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_HEADER: r_header <= i_cfg_data[BYTE_W-1:0];
                    REG_TAIL:   r_tail   <= i_cfg_data;
                    default:    r_tail   <= r_tail;
                endcase
            end
            if (i_cmd.accept && !drop) begin
                if (o_status.match) begin
                    r_wpos   <= '0;
                    r_window <= '0;
                end else begin
                    r_wpos   <= n_wpos;
                    r_window <= n_window;
                end
            end
        end
    end

    // frame snapshot and read pointer
    always_ff @(posedge i_clk) begin
        r_byte0 <= n_byte0;
        r_byte1 <= n_byte1;
        if (i_cmd.accept && o_status.match) begin
            r_len <= n_len;
            r_act <= n_act;
            r_rd  <= '0;
        end else if (i_cmd.pop) begin
            r_rd <= r_rd + AW'(1);
        end
        if (i_cmd.load) begin
            r_frame_byte <= rdata;
            r_byte_index <= INDEX_W'(r_rd);
            r_last_byte  <= rd_last;
        end
    end

    sfe_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store),
        .i_waddr (r_wpos[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (r_rd),
        .o_rdata (rdata)
    );

    assign o_frame_byte   = r_frame_byte;
    assign o_byte_index   = r_byte_index;
    assign o_last_byte    = r_last_byte;
    assign o_frame_length = r_len;
    assign o_action       = r_act;

endmodule

>>> rtl/serial_frame_extractor_top.sv
// Serial frame extractor: pulls header/tail framed messages out of a UART byte stream.
// Input channel (i_in_valid / o_in_stall / i_rx_byte): one received byte per
// transaction. Bytes that arrive with no frame open and do not equal the header
// byte are dropped. Accepted bytes are stored up to FRAME_DEPTH; further bytes
// only feed the tail window.
// Output channel (o_out_valid / i_out_stall): one transaction per stored byte of
// a completed frame, with its index, a last mark, the frame length and the action.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 header byte, index 1 tail
// pattern; always ready, write it only while idle.
// A byte that does not close a frame leaves the input ready for the next byte. A
// closing byte starts a dump; each frame byte passes through the store read, output
// load and hold states; the read state waits on the registered read port of the store.
// The first frame byte is valid in the hold state that follows the read and load states.
// Input is stalled during a dump. While i_out_stall is high the output payload
// and valid hold. Reset clears the position, the window, the controller and
// loads the default header (0xAA) and tail (0xFFFCFFFF); the store is not cleared.
module serial_frame_extractor_top #(
    parameter int unsigned FRAME_DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input byte channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [sfe_pkg::BYTE_W-1:0]  i_rx_byte,
    // frame output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [sfe_pkg::BYTE_W-1:0]  o_frame_byte,
    output logic [sfe_pkg::INDEX_W-1:0] o_byte_index,
    output logic                        o_last_byte,
    output logic [sfe_pkg::POS_W-1:0]   o_frame_length,
    output logic [sfe_pkg::ACT_W-1:0]   o_action,
    // configuration write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [31:0]                 i_cfg_data
);
    import sfe_pkg::*;

    t_cmd    cmd;
    t_status status;

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    sfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // store, window, tail compare and output register
    sfe_dp #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_rx_byte      (i_rx_byte),
        .o_frame_byte   (o_frame_byte),
        .o_byte_index   (o_byte_index),
        .o_last_byte    (o_last_byte),
        .o_frame_length (o_frame_length),
        .o_action       (o_action)
    );

endmodule
